/* design/fm_index_backward_search_core_assert.svh */
// Assertion macros shared by the FM-index search core.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef FM_INDEX_BACKWARD_SEARCH_CORE_ASSERT_SVH
`define FM_INDEX_BACKWARD_SEARCH_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMBS_ASSERT_IMP(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FMBS_ASSERT_NXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

/* design/fmbs_pkg.sv */
package fmbs_pkg;

	// Default size of the symbol store.
	localparam int MAX_TEXT_DEF = 1024;

	// Fixed field widths.
	localparam int SYM_W       = 3;
	localparam int RANGE_W     = 11;
	localparam int NUM_CLASSES = 5;

	// Symbol classes: sentinel or other, then A, C, G and T as 1 to 4.
	localparam logic [SYM_W-1:0] SYM_SENTINEL = 3'd0;
	localparam logic [SYM_W-1:0] SYM_T        = 3'd4;

	// Command codes.
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// One result beat as it leaves the search engine.
	typedef struct packed {
		logic               found;
		logic [RANGE_W-1:0] range_low;
		logic [RANGE_W-1:0] range_high;
		logic               overflow;
	} fmbs_result_t;

	// Codes above T fold onto the sentinel class.
	function automatic logic [SYM_W-1:0] sym_class(input logic [SYM_W-1:0] s);
		return (s > SYM_T) ? SYM_SENTINEL : s;
	endfunction

endpackage

/* design/fmbs_in_if.sv */
interface fmbs_in_if;
	import fmbs_pkg::*;

	logic             valid;
	logic             ready;
	logic             cmd;
	logic [SYM_W-1:0] symbol;
	logic             last;

	modport source (output valid, output cmd, output symbol, output last, input ready);
	modport sink   (input valid, input cmd, input symbol, input last, output ready);
endinterface

/* design/fmbs_out_if.sv */
interface fmbs_out_if;
	import fmbs_pkg::*;

	logic               valid;
	logic               ready;
	logic               found;
	logic [RANGE_W-1:0] range_low;
	logic [RANGE_W-1:0] range_high;
	logic               overflow;

	modport source (output valid, output found, output range_low, output range_high,
		output overflow, input ready);
	modport sink   (input valid, input found, input range_low, input range_high,
		input overflow, output ready);
endinterface

/* design/fmbs_store.sv */
module fmbs_store #(
	parameter int DEPTH = fmbs_pkg::MAX_TEXT_DEF,
	parameter int DW    = fmbs_pkg::SYM_W + $clog2(fmbs_pkg::MAX_TEXT_DEF + 1)
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);
	logic [DW-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* design/fmbs_engine.sv */
`include "fm_index_backward_search_core_assert.svh"

module fmbs_engine #(
	parameter int MAX_TEXT = fmbs_pkg::MAX_TEXT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	fmbs_in_if.sink               din,
	output logic                  res_valid,
	input  logic                  res_ready,
	output fmbs_pkg::fmbs_result_t res
);
	import fmbs_pkg::*;

	localparam int AW = $clog2(MAX_TEXT);
	localparam int CW = $clog2(MAX_TEXT + 1);
	localparam int DW = SYM_W + CW;
	localparam logic [CW-1:0] LEN_MAX = CW'(MAX_TEXT);

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_SCAN_UP = 4'b0010,
		ST_SCAN_DN = 4'b0100,
		ST_EMIT    = 4'b1000
	} state_t;

	// Control state.
	state_t         state_q;
	logic [CW-1:0]  counts_q [NUM_CLASSES];
	logic [CW-1:0]  len_q;
	logic           ovf_q;
	logic           active_q;
	logic           missed_q;
	logic [CW-1:0]  start_q;
	logic [CW-1:0]  stop_q;
	logic           stop_dn_q;
	logic           rv_s1;

	// Working registers of the current query symbol.
	logic [CW-1:0]    hi_q;
	logic [CW-1:0]    ptr_q;
	logic [CW-1:0]    xaddr_q;
	logic [SYM_W-1:0] sym_q;
	logic             last_q;
	logic [CW-1:0]    base_q;
	logic [CW-1:0]    lo_res_q;
	logic [CW-1:0]    raddr_s1;

	// Memory port signals.
	logic          wr_en;
	logic [AW-1:0] waddr;
	logic [DW-1:0] wdata;
	logic          rd_en;
	logic [DW-1:0] rdata;

	logic             in_acc;
	logic [SYM_W-1:0] in_sym;
	logic [CW-1:0]    lo0;
	logic [CW-1:0]    hi0;
	logic             miss0;
	logic [CW-1:0]    len_m1;
	logic [CW-1:0]    hi_c;
	logic             q_miss;
	logic [CW-1:0]    base_c;
	logic [SYM_W-1:0] rd_sym;
	logic [CW-1:0]    rd_rank;
	logic             rd_hit;
	logic [CW-1:0]    lf_val;

	fmbs_store #(
		.DEPTH (MAX_TEXT),
		.DW    (DW)
	) u_store (
		.clk   (clk),
		.wr_en (wr_en),
		.waddr (waddr),
		.wdata (wdata),
		.rd_en (rd_en),
		.raddr (ptr_q[AW-1:0]),
		.rdata (rdata)
	);

	// Input handshake: items are taken only between scans.
	assign din.ready = (state_q == ST_IDLE);
	assign in_acc    = din.valid && din.ready;
	assign in_sym    = sym_class(din.symbol);

	// Load path: append the symbol with its running rank.
	assign wr_en = in_acc && (din.cmd == CMD_LOAD) && (len_q < LEN_MAX);
	assign waddr = len_q[AW-1:0];
	assign wdata = {in_sym, counts_q[in_sym] + CW'(1)};

	// Starting range of a query symbol, clipped to the loaded text.
	always_comb begin
		lo0    = active_q ? start_q : '0;
		len_m1 = len_q - CW'(1);
		hi0    = active_q ? stop_q : len_m1;
		miss0  = active_q ? missed_q : (len_q == '0);
		hi_c   = (hi0 > len_m1) ? len_m1 : hi0;
		q_miss = miss0 || (lo0 >= len_q) || (lo0 > hi_c);
	end

	// First row of the symbol's class in the sorted column.
	always_comb begin
		base_c = '0;
		for (int i = 1; i < NUM_CLASSES; i++) begin
			if (SYM_W'(i) < in_sym) begin
				base_c = base_c + counts_q[i];
			end
		end
	end

	// Returned store entry and its LF-mapped row.
	assign rd_sym  = rdata[DW-1 -: SYM_W];
	assign rd_rank = rdata[CW-1:0];
	assign rd_hit  = rv_s1 && (rd_sym == sym_q);
	assign lf_val  = (sym_q == SYM_SENTINEL) ? '0 : base_q + rd_rank;

	// One read per cycle while scanning; stop issuing once a match returns.
	always_comb begin
		rd_en = 1'b0;
		case (state_q)
			ST_SCAN_UP: rd_en = (ptr_q <= hi_q) && !rd_hit;
			ST_SCAN_DN: rd_en = !stop_dn_q && !rd_hit;
			default:    rd_en = 1'b0;
		endcase
	end

	// Result beat.
	always_comb begin
		res_valid      = (state_q == ST_EMIT);
		res.found      = !missed_q;
		res.range_low  = missed_q ? '0 : RANGE_W'(start_q);
		res.range_high = missed_q ? '0 : RANGE_W'(stop_q);
		res.overflow   = ovf_q;
	end

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				counts_q[i] <= '0;
			end
			len_q     <= '0;
			ovf_q     <= 1'b0;
			active_q  <= 1'b0;
			missed_q  <= 1'b0;
			start_q   <= '0;
			stop_q    <= '0;
			stop_dn_q <= 1'b0;
			rv_s1     <= 1'b0;
		end else begin
			rv_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (din.cmd == CMD_LOAD)) begin
						if (len_q >= LEN_MAX) begin
							ovf_q <= 1'b1;
						end else begin
							counts_q[in_sym] <= counts_q[in_sym] + CW'(1);
							len_q            <= len_q + CW'(1);
						end
					end else if (in_acc) begin
						active_q <= 1'b1;
						missed_q <= q_miss;
						if (q_miss) begin
							state_q <= din.last ? ST_EMIT : ST_IDLE;
						end else begin
							state_q <= ST_SCAN_UP;
						end
					end
				end
				ST_SCAN_UP: begin
					if (rd_hit) begin
						stop_dn_q <= 1'b0;
						state_q   <= ST_SCAN_DN;
					end else if (rv_s1 && (raddr_s1 == hi_q)) begin
						missed_q <= 1'b1;
						state_q  <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_SCAN_DN: begin
					if (rd_hit) begin
						start_q <= lo_res_q;
						stop_q  <= lf_val;
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end else if (rd_en && (ptr_q == xaddr_q)) begin
						stop_dn_q <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (res_ready) begin
						active_q <= 1'b0;
						missed_q <= 1'b0;
						start_q  <= '0;
						stop_q   <= '0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Scan pointers and per-symbol operands.
	always_ff @(posedge clk) begin
		raddr_s1 <= ptr_q;
		if (in_acc && (din.cmd == CMD_QUERY)) begin
			ptr_q  <= lo0;
			hi_q   <= hi_c;
			sym_q  <= in_sym;
			last_q <= din.last;
			base_q <= base_c;
		end else if (state_q == ST_SCAN_UP) begin
			if (rd_hit) begin
				lo_res_q <= lf_val;
				xaddr_q  <= raddr_s1;
				ptr_q    <= hi_q;
			end else if (rd_en) begin
				ptr_q <= ptr_q + CW'(1);
			end
		end else if (state_q == ST_SCAN_DN) begin
			if (rd_en && (ptr_q != xaddr_q)) begin
				ptr_q <= ptr_q - CW'(1);
			end
		end
	end

	`FMBS_ASSERT_IMP(a_len_bound, 1'b1, len_q <= LEN_MAX, "text length beyond store size")
	`FMBS_ASSERT_NXT(a_ovf_sticky, ovf_q, ovf_q, "overflow flag cleared without reset")
	`FMBS_ASSERT_IMP(a_rv_in_scan, rv_s1, state_q == ST_SCAN_UP || state_q == ST_SCAN_DN, "read data returned outside a scan")
	`FMBS_ASSERT_IMP(a_up_ptr, state_q == ST_SCAN_UP, ptr_q <= hi_q + CW'(1), "upward scan ran past the range end")
endmodule

/* design/fm_index_backward_search_core.sv */
// Channel  Dir  Beat payload                               Beat taken when
// din      in   cmd, symbol, last                          valid && ready
// dout     out  found, range_low, range_high, overflow     valid && ready
//
// Load beats are taken back to back. A query symbol walks the store's single read port
// one row a cycle, up from the range start to the first hit and then down from the range
// end to the last hit; each walk waits on the registered read data. An upward miss ends
// at the range end, and a symbol after a miss is skipped without a scan. The last query
// symbol hands its result to the output register from the emit state.
// Reset clears counts, length, range and flags at once; the store itself is not cleared.
// din.ready is low during a scan and while a finished result waits for the output register.
module fm_index_backward_search_core #(
	parameter int MAX_TEXT = fmbs_pkg::MAX_TEXT_DEF
) (
	input logic         clk,
	input logic         arst_n,
	fmbs_in_if.sink     din,
	fmbs_out_if.source  dout
);
	import fmbs_pkg::*;

	logic         res_valid;
	logic         res_ready;
	fmbs_result_t res;
	logic         out_vld_q;
	fmbs_result_t out_data_q;

	fmbs_engine #(
		.MAX_TEXT (MAX_TEXT)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: takes a new result once the held beat is gone.
	assign res_ready = !out_vld_q || dout.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_vld_q <= 1'b1;
		end else if (dout.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res;
		end
	end

	assign dout.valid      = out_vld_q;
	assign dout.found      = out_data_q.found;
	assign dout.range_low  = out_data_q.range_low;
	assign dout.range_high = out_data_q.range_high;
	assign dout.overflow   = out_data_q.overflow;
endmodule
